// ===== design/assert_macros.svh =====
// Assertion macros used by the allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define FFBA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked at the clock edge after each edge with reset low.
`define FFBA_ASSERT_POST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) !rst_n |=> prop) \
        else $error("assertion failed");

`endif

// ===== design/ffba_pkg.sv =====
// Package: types and constants of the first-fit block allocator.
`default_nettype none
package ffba_pkg;
    localparam int MAX_BLOCKS   = 64;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int PAGE_SHIFT   = 12;
    localparam int HEADER_BYTES = 16;
    localparam int GAP_BYTES    = 16;
    localparam int ADDR_W       = 48;
    localparam int SZ_W         = 21;
    localparam int PG_W         = 9;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD     = 2'd1;
    localparam logic [1:0] ST_OOM     = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic CFG_HEAP_BASE  = 1'b0;
    localparam logic CFG_PAGE_LIMIT = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [SZ_W-1:0]   request_bytes;
        logic [ADDR_W-1:0] block_address;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] payload_address;
        logic [SZ_W-1:0]   bytes_in_use;
        logic [SZ_W-1:0]   heap_bytes;
    } t_out_item;

    typedef struct packed {
        logic [SZ_W-1:0] offset;
        logic [SZ_W-1:0] size;
        logic            in_use;
    } t_entry;

    typedef struct packed {
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic [6:0]        k;
        logic [ADDR_W-1:0] c;
    } t_alu_req;

    typedef struct packed {
        logic [ADDR_W-1:0] sum;
        logic              ge;
        logic              eq;
    } t_alu_rsp;
endpackage
`default_nettype wire

// ===== design/first_fit_block_allocator.sv =====
// Top level: first-fit heap block allocator with sequencer, block table and shared ALU.
//
// Usage:
//   Requests enter on i_in_valid / o_in_stall with payload i_in_data (allocate or free).
//   One result beat per request leaves on o_out_valid / i_out_stall with o_out_data.
//   Configuration (heap base, page limit) is written on i_cfg_valid / o_cfg_ready
//   with i_cfg_index and i_cfg_data. The user must write it only while no request
//   is in flight; the block does not enforce this.
// Sequencing:
//   Requests are served one at a time; o_in_stall is high until the result has
//   moved to the output register. A request walks the block table one entry at a
//   time in two steps (RAM read, evaluate); the table RAM has a single read port
//   and the ALU is shared. A bad-value request goes straight to the done step.
// Reset:
//   i_rst_n low clears the block count, append offset and byte count, maps one page,
//   sets heap base 0 and page limit 256. The table contents are not cleared.
// Output stall:
//   A finished result waits in the output register while i_out_stall is high; the
//   next request may be accepted meanwhile and holds in its last step until the
//   output register is free.
`default_nettype none
`include "assert_macros.svh"
module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_item   i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_item       o_out_data,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_index,
    input  wire logic [ADDR_W-1:0] i_cfg_data
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_EVAL   = 3'd2;
    localparam logic [2:0] S_FIT    = 3'd3;
    localparam logic [2:0] S_APPCHK = 3'd4;
    localparam logic [2:0] S_APPWR  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_base;
    logic [PG_W-1:0]   r_limit;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SZ_W:0]     r_append, n_append;
    logic [PG_W-1:0]   r_pages, n_pages;
    logic [SZ_W-1:0]   r_used, n_used;
    logic [CNT_W-1:0]  r_idx, n_idx;
    t_in_item          r_item, n_item;
    logic [1:0]        r_status, n_status;
    logic [ADDR_W-1:0] r_payload, n_payload;
    logic              r_out_valid;
    t_out_item         r_out_data;

    t_entry            rd_entry, wr_entry;
    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr;
    t_alu_req          alu_req;
    t_alu_rsp          alu_rsp;
    logic [SZ_W-1:0]   map_end;
    logic [SZ_W:0]     add_amt, sub_amt;
    logic [SZ_W+1:0]   add_sum;
    logic [CNT_W-1:0]  idx_inc;
    logic              can_map, out_free;

    assign map_end  = {r_pages, {PAGE_SHIFT{1'b0}}};
    assign can_map  = (r_pages < r_limit);
    assign idx_inc  = r_idx + 1'b1;
    assign add_amt  = {1'b0, r_item.request_bytes} + (SZ_W+1)'(HEADER_BYTES + GAP_BYTES);
    assign add_sum  = {2'b00, r_used} + {1'b0, add_amt};
    assign sub_amt  = {1'b0, rd_entry.size} + (SZ_W+1)'(HEADER_BYTES);
    assign out_free = !r_out_valid || !i_out_stall;

    ffba_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(MAX_BLOCKS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(wr_entry),
        .i_re   (ram_re),
        .i_raddr(r_idx[IDX_W-1:0]),
        .o_rdata(rd_entry)
    );

    ffba_alu u_alu (
        .i_req(alu_req),
        .o_rsp(alu_rsp)
    );

    // operand selection for the shared ALU
    always_comb begin
        alu_req = '0;
        case (r_state)
            S_EVAL: begin
                if (r_item.operation == OP_FREE) begin
                    alu_req.a = r_base;
                    alu_req.b = {{(ADDR_W-SZ_W){1'b0}}, rd_entry.offset};
                    alu_req.k = 7'(HEADER_BYTES);
                    alu_req.c = r_item.block_address;
                end else begin
                    alu_req.a = {{(ADDR_W-SZ_W){1'b0}}, rd_entry.offset};
                    alu_req.b = {{(ADDR_W-SZ_W){1'b0}}, rd_entry.size};
                    alu_req.k = 7'(HEADER_BYTES + GAP_BYTES);
                    alu_req.c = {{(ADDR_W-SZ_W){1'b0}}, map_end};
                end
            end
            S_FIT: begin
                alu_req.a = r_base;
                alu_req.b = {{(ADDR_W-SZ_W){1'b0}}, rd_entry.offset};
                alu_req.k = 7'(HEADER_BYTES);
            end
            S_APPCHK: begin
                alu_req.a = {{(ADDR_W-SZ_W-1){1'b0}}, r_append};
                alu_req.b = {{(ADDR_W-SZ_W){1'b0}}, r_item.request_bytes};
                alu_req.k = 7'(HEADER_BYTES);
                alu_req.c = {{(ADDR_W-SZ_W){1'b0}}, map_end};
            end
            S_APPWR: begin
                alu_req.a = r_base;
                alu_req.b = {{(ADDR_W-SZ_W-1){1'b0}}, r_append};
                alu_req.k = 7'(HEADER_BYTES);
            end
            default: alu_req = '0;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_append  = r_append;
        n_pages   = r_pages;
        n_used    = r_used;
        n_idx     = r_idx;
        n_item    = r_item;
        n_status  = r_status;
        n_payload = r_payload;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_idx[IDX_W-1:0];
        wr_entry  = rd_entry;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item    = i_in_data;
                    n_idx     = '0;
                    n_payload = '0;
                    n_status  = ST_OK;
                    if (i_in_data.operation == OP_ALLOC) begin
                        if (i_in_data.request_bytes == '0) begin
                            n_status = ST_BAD;
                            n_state  = S_DONE;
                        end else if (r_count == '0) begin
                            n_state = S_APPCHK;
                        end else begin
                            n_state = S_READ;
                        end
                    end else begin
                        if (i_in_data.block_address == '0) begin
                            n_status = ST_BAD;
                            n_state  = S_DONE;
                        end else if (r_count == '0) begin
                            n_status = ST_UNKNOWN;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_READ;
                        end
                    end
                end
            end
            S_READ: begin
                ram_re  = 1'b1;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_idx = idx_inc;
                if (idx_inc == r_count) begin
                    n_state = (r_item.operation == OP_ALLOC) ? S_APPCHK : S_DONE;
                    if (r_item.operation == OP_FREE) begin
                        n_status = ST_UNKNOWN;
                    end
                end else begin
                    n_state = S_READ;
                end
                if (r_item.operation == OP_FREE) begin
                    if (alu_rsp.eq) begin
                        ram_we          = 1'b1;
                        wr_entry.in_use = 1'b0;
                        n_used          = (sub_amt >= {1'b0, r_used}) ? '0
                                        : r_used - sub_amt[SZ_W-1:0];
                        n_status        = ST_OK;
                        n_idx           = r_idx;
                        n_state         = S_DONE;
                    end
                end else if (!rd_entry.in_use) begin
                    if (rd_entry.size >= r_item.request_bytes) begin
                        n_idx   = r_idx;
                        n_state = S_FIT;
                    end else if (alu_rsp.ge) begin
                        // block end reaches the heap end: map one more page, or report OOM at the page limit
                        if (can_map) begin
                            n_pages = r_pages + 1'b1;
                        end else begin
                            n_status = ST_OOM;
                            n_state  = S_DONE;
                        end
                    end
                end
            end
            S_FIT: begin
                ram_we          = 1'b1;
                wr_entry.in_use = 1'b1;
                n_payload       = alu_rsp.sum;
                n_used          = (|add_sum[SZ_W+1:SZ_W]) ? '1 : add_sum[SZ_W-1:0];
                n_state         = S_DONE;
            end
            S_APPCHK: begin
                if (r_count >= CNT_W'(MAX_BLOCKS)) begin
                    n_status = ST_OOM;
                    n_state  = S_DONE;
                end else if (alu_rsp.ge) begin
                    if (can_map) begin
                        n_pages = r_pages + 1'b1;
                    end else begin
                        n_status = ST_OOM;
                        n_state  = S_DONE;
                    end
                end else begin
                    n_state = S_APPWR;
                end
            end
            S_APPWR: begin
                ram_we          = 1'b1;
                ram_waddr       = r_count[IDX_W-1:0];
                wr_entry.offset = r_append[SZ_W-1:0];
                wr_entry.size   = r_item.request_bytes;
                wr_entry.in_use = 1'b1;
                n_count         = r_count + 1'b1;
                n_append        = r_append + add_amt;
                n_payload       = alu_rsp.sum;
                n_used          = (|add_sum[SZ_W+1:SZ_W]) ? '1 : add_sum[SZ_W-1:0];
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_limit     <= PG_W'(256);
            r_count     <= '0;
            r_append    <= '0;
            r_pages     <= PG_W'(1);
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_append <= n_append;
            r_pages  <= n_pages;
            r_used   <= n_used;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_HEAP_BASE) begin
                    r_base <= i_cfg_data;
                end else begin
                    r_limit <= i_cfg_data[PG_W-1:0];
                end
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_item    <= n_item;
        r_status  <= n_status;
        r_payload <= n_payload;
        if (r_state == S_DONE && out_free) begin
            r_out_data.status          <= r_status;
            r_out_data.payload_address <= (r_status == ST_OK) ? r_payload : '0;
            r_out_data.bytes_in_use    <= r_used;
            r_out_data.heap_bytes      <= map_end;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

    `FFBA_ASSERT(a_busy_stalls, i_clk, i_rst_n, (r_state != S_IDLE) |-> o_in_stall)
    `FFBA_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= CNT_W'(MAX_BLOCKS))
    `FFBA_ASSERT(a_pages_nonzero, i_clk, i_rst_n, r_pages != '0)
    `FFBA_ASSERT_POST(a_reset_idle, i_clk, i_rst_n, (r_state == S_IDLE) && !r_out_valid)
endmodule
`default_nettype wire

// ===== design/ffba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== design/ffba_alu.sv =====
// Shared add-and-compare unit: sum = a + b + k, compared against c.
`default_nettype none
module ffba_alu
    import ffba_pkg::*;
(
    input  wire t_alu_req i_req,
    output t_alu_rsp      o_rsp
);
    logic [ADDR_W-1:0] sum;

    assign sum       = i_req.a + i_req.b + {{(ADDR_W-7){1'b0}}, i_req.k};
    assign o_rsp.sum = sum;
    assign o_rsp.ge  = (sum >= i_req.c);
    assign o_rsp.eq  = (sum == i_req.c);
endmodule
`default_nettype wire

// ===== dv/ffba_checker.sv =====
// Checker for the first-fit block allocator: predicts each result and compares it.
module ffba_checker
    import ffba_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_stall,
    input  wire t_in_item          i_in_data,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_stall,
    input  wire t_out_item         i_out_data,
    input  wire logic              i_cfg_valid,
    input  wire logic              i_cfg_ready,
    input  wire logic              i_cfg_index,
    input  wire logic [ADDR_W-1:0] i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint PAGE_SZ = 64'd1 << PAGE_SHIFT;
    localparam longint SAT21   = (64'd1 << SZ_W) - 1;

    // predictor state
    longint    base_addr;
    longint    pg_limit;
    longint    blk_off [MAX_BLOCKS];
    longint    blk_size [MAX_BLOCKS];
    bit        blk_busy [MAX_BLOCKS];
    int        blk_count;
    longint    tail_off;
    longint    pages;
    longint    used;
    t_out_item expected_results [$];

    assign o_pending = expected_results.size();

    function automatic bit grow_heap();
        if (pages >= pg_limit) return 0;
        pages++;
        return 1;
    endfunction

    function automatic void add_used(longint amt);
        used = (used + amt > SAT21) ? SAT21 : used + amt;
    endfunction

    function automatic t_out_item predict_request(t_in_item req);
        t_out_item res;
        longint    rq;
        longint    addr;
        longint    nxt;
        bit        done;
        res  = '0;
        rq   = longint'(req.request_bytes);
        addr = longint'(req.block_address);
        done = 0;
        if (req.operation == OP_ALLOC) begin
            if (rq == 0) begin
                res.status = ST_BAD;
                done = 1;
            end
            for (int i = 0; i < blk_count && !done; i++) begin
                if (blk_busy[i]) continue;
                if (blk_size[i] >= rq) begin
                    blk_busy[i] = 1;
                    add_used(rq + GAP_BYTES + HEADER_BYTES);
                    res.status = ST_OK;
                    res.payload_address = ADDR_W'(base_addr + blk_off[i] + HEADER_BYTES);
                    done = 1;
                end else begin
                    nxt = blk_off[i] + blk_size[i] + HEADER_BYTES + GAP_BYTES;
                    if (nxt >= pages * PAGE_SZ && !grow_heap()) begin
                        res.status = ST_OOM;
                        done = 1;
                    end
                end
            end
            if (!done && blk_count >= MAX_BLOCKS) begin
                res.status = ST_OOM;
                done = 1;
            end
            while (!done && tail_off + rq + HEADER_BYTES >= pages * PAGE_SZ) begin
                if (!grow_heap()) begin
                    res.status = ST_OOM;
                    done = 1;
                end
            end
            if (!done) begin
                blk_off[blk_count]  = tail_off;
                blk_size[blk_count] = rq;
                blk_busy[blk_count] = 1;
                blk_count++;
                res.status = ST_OK;
                res.payload_address = ADDR_W'(base_addr + tail_off + HEADER_BYTES);
                tail_off += rq + HEADER_BYTES + GAP_BYTES;
                add_used(rq + GAP_BYTES + HEADER_BYTES);
            end
        end else if (addr == 0) begin
            res.status = ST_BAD;
        end else begin
            res.status = ST_UNKNOWN;
            for (int i = 0; i < blk_count && res.status == ST_UNKNOWN; i++) begin
                if (longint'(ADDR_W'(base_addr + blk_off[i] + HEADER_BYTES)) == addr) begin
                    used = (blk_size[i] + HEADER_BYTES >= used) ? 0
                         : used - blk_size[i] - HEADER_BYTES;
                    blk_busy[i] = 0;
                    res.status = ST_OK;
                end
            end
        end
        res.bytes_in_use = SZ_W'(used);
        res.heap_bytes   = SZ_W'(pages * PAGE_SZ);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            base_addr = 0;
            pg_limit  = 256;
            blk_count = 0;
            tail_off  = 0;
            pages     = 1;
            used      = 0;
            expected_results.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_HEAP_BASE) base_addr = longint'(i_cfg_data);
                else pg_limit = longint'(i_cfg_data[PG_W-1:0]);
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(predict_request(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result beat %p", i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want.status !== i_out_data.status
                            || want.payload_address !== i_out_data.payload_address
                            || want.bytes_in_use !== i_out_data.bytes_in_use
                            || want.heap_bytes !== i_out_data.heap_bytes) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p got %p", want, i_out_data);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== dv/testbench.sv =====
// Testbench top: stimulus, configuration phases and verdict for the allocator.
module testbench;
    import ffba_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    t_in_item          in_data;
    logic              out_valid;
    logic              out_stall;
    t_out_item         out_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_index;
    logic [ADDR_W-1:0] cfg_data;
    int                fail_count;
    int                pending;
    int                idle_cycles;
    bit                stall_mode;

    // addresses handed out since the start of the random phases, for frees that hit
    logic [ADDR_W-1:0] handed_out [$];

    first_fit_block_allocator dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    ffba_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // receiver stall pattern: runs of random stalling, or none
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 0;
            stall_mode <= 0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
            out_stall <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b0;
        end
    end

    // watchdog on cycles with no accepted beat
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // valid stays high after the accepting edge; the next beat or a gap replaces it
    task automatic send_request(input logic op, input logic [SZ_W-1:0] bytes,
                                input logic [ADDR_W-1:0] addr);
        in_valid <= 1;
        in_data  <= '{operation: op, request_bytes: bytes, block_address: addr};
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // burst-with-gap pacing; gap drawn once per burst
    int burst_left;
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic write_cfg(input logic idx, input logic [ADDR_W-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0 || in_stall) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic random_requests(input int count, input int max_bytes);
        logic [ADDR_W-1:0] a;
        int                r;
        for (int n = 0; n < count; n++) begin
            pace();
            r = $urandom_range(0, 99);
            if (r < 55) begin
                send_request(OP_ALLOC, SZ_W'($urandom_range(1, max_bytes)), 48'($urandom));
            end else if (r < 85 && handed_out.size() > 0) begin
                send_request(OP_FREE, SZ_W'($urandom),
                             handed_out[$urandom_range(0, handed_out.size() - 1)]);
            end else if (r < 92) begin
                a = {16'($urandom), 32'($urandom)};
                send_request(OP_FREE, SZ_W'($urandom), a);
            end else begin
                send_request(1'($urandom_range(0, 1)), SZ_W'($urandom), '0);
            end
        end
    endtask

    // collect addresses from accepted allocate results
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall && out_data.payload_address != 0)
            handed_out.push_back(out_data.payload_address);
    end

    initial begin
        rst_n      = 0;
        in_valid   = 0;
        in_data    = '0;
        cfg_valid  = 0;
        cfg_index  = CFG_HEAP_BASE;
        cfg_data   = '0;
        burst_left = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: bad values, extremes, unknown frees, reuse
        send_request(OP_ALLOC, '0, '0);
        send_request(OP_FREE, '0, '0);
        send_request(OP_ALLOC, 21'd1, '1);
        send_request(OP_ALLOC, 21'd4000, '0);
        send_request(OP_ALLOC, 21'd100, '0);
        send_request(OP_FREE, '1, 48'd16);
        send_request(OP_FREE, '0, 48'd16);
        send_request(OP_FREE, '0, '1);
        send_request(OP_ALLOC, 21'd1, '0);
        send_request(OP_ALLOC, 21'h1FFFFF, '0);
        send_request(OP_ALLOC, 21'd1048576, '0);
        send_request(OP_ALLOC, 21'd50000, '0);
        send_request(OP_FREE, '0, 48'd4048);
        send_request(OP_ALLOC, 21'd60, '0);
        drain();

        // tiny limit, large base near the top of the address space
        write_cfg(CFG_PAGE_LIMIT, 48'd1);
        write_cfg(CFG_HEAP_BASE, 48'hFFFF_FFFF_FF00);
        rst_n <= 1;
        handed_out.delete();
        random_requests(250, 600);
        drain();

        write_cfg(CFG_PAGE_LIMIT, 48'd0);
        write_cfg(CFG_HEAP_BASE, 48'h0000_1234_5000);
        random_requests(100, 300);
        drain();

        write_cfg(CFG_PAGE_LIMIT, 48'd256);
        write_cfg(CFG_HEAP_BASE, 48'hFFFF_FFFF_FFFF);
        random_requests(450, 2000);
        drain();

        write_cfg(CFG_PAGE_LIMIT, 48'h1FF);
        write_cfg(CFG_HEAP_BASE, {16'($urandom), 32'($urandom)});
        random_requests(500, 40000);
        drain();

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
